// ===== hdl/ast_pkg.sv =====
package ast_pkg;

    // event modes
    localparam logic [2:0] MODE_GOAL = 3'd0;
    localparam logic [2:0] MODE_PLAN = 3'd1;
    localparam logic [2:0] MODE_DIST = 3'd2;
    localparam logic [2:0] MODE_ODOM = 3'd3;
    localparam logic [2:0] MODE_EVAL = 3'd4;
    localparam logic [2:0] MODE_BEAT = 3'd5;

    // navigation states
    localparam logic [2:0] ST_WAIT    = 3'd0;
    localparam logic [2:0] ST_PLAN    = 3'd1;
    localparam logic [2:0] ST_MOVE    = 3'd2;
    localparam logic [2:0] ST_ARRIVED = 3'd3;

    // detail codes
    localparam logic [1:0] DET_STARTED = 2'd0;
    localparam logic [1:0] DET_GOAL    = 2'd1;
    localparam logic [1:0] DET_PLAN    = 2'd2;
    localparam logic [1:0] DET_REACHED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ARRIVE_DIST = 2'd0;
    localparam logic [1:0] REG_STOP_SPEED  = 2'd1;
    localparam logic [1:0] REG_HOLD_TIME   = 2'd2;
    localparam logic [1:0] REG_FRESH_TIME  = 2'd3;

    localparam logic [15:0] ARRIVE_DIST_RST = 16'd200;
    localparam logic [15:0] STOP_SPEED_RST  = 16'd50;
    localparam logic [15:0] HOLD_TIME_RST   = 16'd800;
    localparam logic [15:0] FRESH_TIME_RST  = 16'd1000;
    localparam logic [31:0] STOP_LIM_RST    = 32'd2500;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        now_ms;
        logic               plan_nonempty;
        logic               sample_valid;
        logic signed [31:0] distance_mm;
        logic signed [15:0] vel_x_mm_s;
        logic signed [15:0] vel_y_mm_s;
    } ast_evt_t;

    typedef struct packed {
        logic [2:0]  nav_state;
        logic [1:0]  detail_code;
        logic [31:0] stamp_ms;
    } ast_sts_t;

    // classified word passed from front to back
    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        now_ms;
        logic               plan_nonempty;
        logic signed [31:0] distance_mm;
        logic [31:0]        speed_sq;
    } ast_item_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [15:0] data;
    } ast_cfg_t;

    typedef struct packed {
        logic full;
        logic valid;
    } ast_q_status_t;

endpackage

// ===== hdl/ast_stream_if.sv =====
interface ast_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/arrival_status_tracker.sv =====
// Channel | Dir | Handshake    | Payload
// evt     | in  | valid/ready  | mode, now_ms, plan_nonempty, sample_valid, distance_mm,
//         |     |              | vel_x_mm_s, vel_y_mm_s
// sts     | out | valid/ready  | nav_state, detail_code, stamp_ms
// cfg     | in  | cfg_we only  | cfg_index (0..3), cfg_data (16 bits)
//
// One event is taken per cycle unless the front register holds a word and the queue is full;
// its status word, if any, goes via front register, queue, back execution into the output register.
// The back executes one event a cycle while the output register is free or being read (sustained rate).
// Reset clears control state and loads config defaults at once; no clearing pass follows.
// A stalled status word holds the back; the two-word queue and the front register
// keep taking events until they fill.
module arrival_status_tracker
    import ast_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ast_stream_if.sink   evt,
    ast_stream_if.source sts,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    ast_cfg_t      cfg;
    ast_q_status_t q_status;
    ast_item_t     push_item;
    ast_item_t     head;
    logic          push;
    logic          pop;
    ast_sts_t      sts_word;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ast_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt.valid),
        .evt_ready   (evt.ready),
        .evt_payload (evt.payload),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    ast_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    ast_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_status    (q_status),
        .item        (head),
        .pop         (pop),
        .sts_valid   (sts.valid),
        .sts_ready   (sts.ready),
        .sts_payload (sts_word)
    );

    assign sts.payload = sts_word;

endmodule

// ===== hdl/ast_front.sv =====
module ast_front
    import ast_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_ready,
    input  ast_evt_t      evt_payload,
    input  ast_q_status_t q_status,
    output logic          push,
    output ast_item_t     push_item
);

    logic               stage_valid_reg, stage_valid_next;
    logic [2:0]         op_reg;
    logic [31:0]        now_reg;
    logic               plan_reg;
    logic signed [31:0] dist_reg;
    logic [30:0]        sq_x_reg;
    logic [30:0]        sq_y_reg;
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic               accept;
    logic               keep;

    assign sq_x = 32'(evt_payload.vel_x_mm_s) * 32'(evt_payload.vel_x_mm_s);
    assign sq_y = 32'(evt_payload.vel_y_mm_s) * 32'(evt_payload.vel_y_mm_s);

    assign push      = stage_valid_reg && !q_status.full;
    assign evt_ready = !stage_valid_reg || !q_status.full;
    assign accept    = evt_valid && evt_ready;

    // drop words that can change nothing in the back
    always_comb
    begin
        case (evt_payload.mode)
            MODE_GOAL, MODE_EVAL, MODE_BEAT: keep = 1'b1;
            MODE_PLAN: keep = evt_payload.plan_nonempty;
            MODE_DIST, MODE_ODOM: keep = evt_payload.sample_valid;
            default: keep = 1'b0;
        endcase
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = keep;
        else if (push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= evt_payload.mode;
            now_reg  <= evt_payload.now_ms;
            plan_reg <= evt_payload.plan_nonempty;
            dist_reg <= evt_payload.distance_mm;
            sq_x_reg <= sq_x[30:0];
            sq_y_reg <= sq_y[30:0];
        end
    end

    always_comb
    begin
        push_item.op            = op_reg;
        push_item.now_ms        = now_reg;
        push_item.plan_nonempty = plan_reg;
        push_item.distance_mm   = dist_reg;
        push_item.speed_sq      = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    end

endmodule

// ===== hdl/ast_fifo.sv =====
module ast_fifo
    import ast_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ast_item_t     push_item,
    input  logic          pop,
    output ast_q_status_t status,
    output ast_item_t     head
);

    ast_item_t            entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

    assign status.full  = (count_reg == CNT_FULL);
    assign status.valid = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

// ===== hdl/ast_back.sv =====
module ast_back
    import ast_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ast_cfg_t      cfg,
    input  ast_q_status_t q_status,
    input  ast_item_t     item,
    output logic          pop,
    output logic          sts_valid,
    input  logic          sts_ready,
    output ast_sts_t      sts_payload
);

    logic [15:0]          arrive_reg, stop_reg, hold_time_reg, fresh_reg;
    logic [31:0]          lim_reg;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           detail_reg, detail_next;
    logic signed [31:0]   dist_reg, dist_next;
    logic                 dist_have_reg, dist_have_next;
    logic [TIME_BITS-1:0] dist_stamp_reg, dist_stamp_next;
    logic [31:0]          speed_reg, speed_next;
    logic                 speed_have_reg, speed_have_next;
    logic [TIME_BITS-1:0] speed_stamp_reg, speed_stamp_next;
    logic                 hold_active_reg, hold_active_next;
    logic [TIME_BITS-1:0] hold_since_reg, hold_since_next;

    logic                 out_valid_reg;
    ast_sts_t             out_reg;

    logic [TIME_BITS-1:0] now_t;
    logic [31:0]          stamp;
    logic [TIME_BITS-1:0] dist_age, speed_age, hold_age;
    logic                 ok;
    logic                 emit;
    logic [2:0]           emit_state;
    logic [1:0]           emit_detail;

    generate
        if (TIME_BITS > 32)
        begin : g_wide
            assign now_t = {{(TIME_BITS-32){1'b0}}, item.now_ms};
            assign stamp = item.now_ms;
        end
        else if (TIME_BITS == 32)
        begin : g_equal
            assign now_t = item.now_ms;
            assign stamp = item.now_ms;
        end
        else
        begin : g_narrow
            assign now_t = item.now_ms[TIME_BITS-1:0];
            assign stamp = {{(32-TIME_BITS){1'b0}}, item.now_ms[TIME_BITS-1:0]};
        end
    endgenerate

    assign pop = q_status.valid && (!out_valid_reg || sts_ready);

    // ages wrap with the time counter
    assign dist_age  = now_t - dist_stamp_reg;
    assign speed_age = now_t - speed_stamp_reg;
    assign hold_age  = now_t - hold_since_reg;

    assign ok = dist_have_reg && speed_have_reg
        && (dist_age <= TIME_BITS'(fresh_reg))
        && (speed_age <= TIME_BITS'(fresh_reg))
        && (dist_reg <= $signed({16'd0, arrive_reg}))
        && (speed_reg <= lim_reg);

    always_comb
    begin
        state_next       = state_reg;
        detail_next      = detail_reg;
        dist_next        = dist_reg;
        dist_have_next   = dist_have_reg;
        dist_stamp_next  = dist_stamp_reg;
        speed_next       = speed_reg;
        speed_have_next  = speed_have_reg;
        speed_stamp_next = speed_stamp_reg;
        hold_active_next = hold_active_reg;
        hold_since_next  = hold_since_reg;
        emit             = 1'b0;
        emit_state       = state_reg;
        emit_detail      = detail_reg;
        if (pop)
        begin
            case (item.op)
                MODE_GOAL:
                begin
                    hold_active_next = 1'b0;
                    dist_have_next   = 1'b0;
                    speed_have_next  = 1'b0;
                    state_next       = ST_PLAN;
                    detail_next      = DET_GOAL;
                    emit             = 1'b1;
                    emit_state       = ST_PLAN;
                    emit_detail      = DET_GOAL;
                end
                MODE_PLAN:
                begin
                    if (state_reg == ST_PLAN && item.plan_nonempty)
                    begin
                        hold_active_next = 1'b0;
                        state_next       = ST_MOVE;
                        detail_next      = DET_PLAN;
                        emit             = 1'b1;
                        emit_state       = ST_MOVE;
                        emit_detail      = DET_PLAN;
                    end
                end
                MODE_DIST:
                begin
                    dist_next       = item.distance_mm;
                    dist_stamp_next = now_t;
                    dist_have_next  = 1'b1;
                end
                MODE_ODOM:
                begin
                    speed_next       = item.speed_sq;
                    speed_stamp_next = now_t;
                    speed_have_next  = 1'b1;
                end
                MODE_EVAL:
                begin
                    if (state_reg != ST_MOVE || !ok)
                        hold_active_next = 1'b0;
                    else if (!hold_active_reg)
                    begin
                        // first good tick only opens the hold window
                        hold_active_next = 1'b1;
                        hold_since_next  = now_t;
                    end
                    else if (hold_age >= TIME_BITS'(hold_time_reg))
                    begin
                        hold_active_next = 1'b0;
                        state_next       = ST_ARRIVED;
                        detail_next      = DET_REACHED;
                        emit             = 1'b1;
                        emit_state       = ST_ARRIVED;
                        emit_detail      = DET_REACHED;
                    end
                end
                MODE_BEAT:
                begin
                    emit = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrive_reg      <= ARRIVE_DIST_RST;
            stop_reg        <= STOP_SPEED_RST;
            hold_time_reg   <= HOLD_TIME_RST;
            fresh_reg       <= FRESH_TIME_RST;
            lim_reg         <= STOP_LIM_RST;
            state_reg       <= ST_WAIT;
            detail_reg      <= DET_STARTED;
            dist_reg        <= '0;
            dist_have_reg   <= 1'b0;
            dist_stamp_reg  <= '0;
            speed_reg       <= '0;
            speed_have_reg  <= 1'b0;
            speed_stamp_reg <= '0;
            hold_active_reg <= 1'b0;
            hold_since_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.we)
            begin
                case (cfg.index)
                    REG_ARRIVE_DIST: arrive_reg    <= cfg.data;
                    REG_STOP_SPEED:  stop_reg      <= cfg.data;
                    REG_HOLD_TIME:   hold_time_reg <= cfg.data;
                    REG_FRESH_TIME:  fresh_reg     <= cfg.data;
                    default: ;
                endcase
            end
            // squared speed limit is a registered copy of the stop speed squared
            lim_reg         <= 32'(stop_reg) * 32'(stop_reg);
            state_reg       <= state_next;
            detail_reg      <= detail_next;
            dist_reg        <= dist_next;
            dist_have_reg   <= dist_have_next;
            dist_stamp_reg  <= dist_stamp_next;
            speed_reg       <= speed_next;
            speed_have_reg  <= speed_have_next;
            speed_stamp_reg <= speed_stamp_next;
            hold_active_reg <= hold_active_next;
            hold_since_reg  <= hold_since_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (sts_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.nav_state   <= emit_state;
            out_reg.detail_code <= emit_detail;
            out_reg.stamp_ms    <= stamp;
        end
    end

    assign sts_valid   = out_valid_reg;
    assign sts_payload = out_reg;

    a_goal_plans: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.op == MODE_GOAL) |=> (state_reg == ST_PLAN && !hold_active_reg))
        else $error("goal did not restart planning");

    a_arrive_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.op == MODE_EVAL && emit) |-> (hold_active_reg && state_reg == ST_MOVE))
        else $error("arrival without an open hold window");

    a_status_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("status word without a popped event");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || sts_ready))
        else $error("pending status overwritten");

endmodule
